>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes of the first-fit heap allocator: operations, result status,
// register indexes, and register widths and reset values.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_TBL_FULL  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_e;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam int unsigned HdrW  = 7;
  localparam int unsigned CfgW  = 20;
  localparam logic [HdrW-1:0] HdrReset   = 7'd16;
  localparam logic [CfgW-1:0] LimitReset = 20'hFFFFF;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Address-ordered block table with first-fit allocate, split, free with
// neighbor merge and reallocate; the table is a single-port-write memory
// walked one entry at a time by a small sequencer.
// Each entry scanned takes a read state and a check state; a split or merge
// shifts entries one at a time; a reallocate scans up to three times.
// One request at a time; ready again the cycle after the result is taken.
// Reset clears count and heap top, presets the registers; no table clear pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned ADDR_BITS  = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [19:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [ADDR_BITS-1:0] req_size_i,
  input  logic [ADDR_BITS-1:0] block_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_BITS-1:0] data_addr_o,
  output logic [2:0]           status_o,
  output logic [ADDR_BITS-1:0] copy_len_o
);

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned EW = 2 * AW + 1;
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_BLOCKS);

  typedef enum logic [17:0] {
    S_IDLE = 18'd1,
    S_ARD  = 18'd2,
    S_ACHK = 18'd4,
    S_ASHR = 18'd8,
    S_ASHW = 18'd16,
    S_SPL1 = 18'd32,
    S_SPL2 = 18'd64,
    S_GROW = 18'd128,
    S_LRD  = 18'd256,
    S_LCHK = 18'd512,
    S_FPRD = 18'd1024,
    S_FPCK = 18'd2048,
    S_FNRD = 18'd4096,
    S_FNCK = 18'd8192,
    S_FWR  = 18'd16384,
    S_RRD  = 18'd32768,
    S_RWR  = 18'd65536,
    S_DONE = 18'd131072
  } state_e;

  state_e state_q, state_d;

  logic [ffha_pkg::HdrW-1:0] hdr_q;
  logic [ffha_pkg::CfgW-1:0] lim_q;
  logic [1:0]    func_q, func_d;
  logic [AW-1:0] req_q, req_d, baddr_q, baddr_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, jdx_q, jdx_d;
  logic [AW-1:0] top_q, top_d;
  logic [EW-1:0] cur_q, cur_d;
  logic [AW-1:0] acc_q, acc_d, base_q, base_d, oldsz_q, oldsz_d;
  logic          phit_q, phit_d, nhit_q, nhit_d, frph_q, frph_d;
  logic [AW-1:0] addr_q, addr_d, copy_q, copy_d;
  logic [2:0]    stat_q, stat_d;

  logic [EW-1:0] tbl_q [MAX_BLOCKS];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;

  logic [ffha_pkg::HdrW-1:0] h7;
  logic [AW-1:0] h, lim_a;
  logic [AW-1:0] e_off, e_size, c_off, c_size;
  logic          e_free;
  logic [CW:0]   idx_p1, jdx_sh;
  logic [1:0]    shamt;
  logic [AW+1:0] grow_end;
  logic          fit_ge;

  assign h7     = (hdr_q == '0) ? ffha_pkg::HdrW'(1) : hdr_q;
  assign h      = AW'(h7);
  assign lim_a  = AW'(lim_q);
  assign e_off  = rd_q[AW-1:0];
  assign e_size = rd_q[2*AW-1:AW];
  assign e_free = rd_q[2*AW];
  assign c_off  = cur_q[AW-1:0];
  assign c_size = cur_q[2*AW-1:AW];
  assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);
  assign shamt  = {1'b0, phit_q} + {1'b0, nhit_q};
  assign jdx_sh = {1'b0, jdx_q} + (CW+1)'(shamt);
  assign fit_ge = {1'b0, e_size} >= ({1'b0, req_q} + {1'b0, h});
  assign grow_end = (AW+2)'(top_q) + (AW+2)'(h) + (AW+2)'(req_q);

  always_comb begin
    logic          fin_a, fin_f;
    logic [2:0]    st_a;
    logic [AW-1:0] ad_a;
    fin_a   = 1'b0;
    fin_f   = 1'b0;
    st_a    = ffha_pkg::ST_OK;
    ad_a    = '0;
    state_d = state_q;
    func_d  = func_q;
    req_d   = req_q;
    baddr_d = baddr_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    jdx_d   = jdx_q;
    top_d   = top_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    base_d  = base_q;
    oldsz_d = oldsz_q;
    phit_d  = phit_q;
    nhit_d  = nhit_q;
    frph_d  = frph_q;
    addr_d  = addr_q;
    copy_d  = copy_q;
    stat_d  = stat_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q[IW-1:0];
    mem_wd  = rd_q;
    mem_ra  = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          req_d   = req_size_i;
          baddr_d = block_addr_i;
          idx_d   = '0;
          frph_d  = 1'b0;
          addr_d  = '0;
          copy_d  = '0;
          stat_d  = ffha_pkg::ST_OK;
          state_d = S_DONE;
          unique case (func_i)
            ffha_pkg::FUNC_ALLOC: begin
              if (req_size_i == '0) stat_d = ffha_pkg::ST_ZERO_SIZE;
              else state_d = S_ARD;
            end
            ffha_pkg::FUNC_FREE: begin
              if (block_addr_i != '0) state_d = S_LRD;
            end
            ffha_pkg::FUNC_REALLOC: begin
              if (req_size_i == '0 && block_addr_i == '0) begin
                stat_d = ffha_pkg::ST_ZERO_SIZE;
              end else if (req_size_i != '0 && block_addr_i == '0) begin
                state_d = S_ARD;
              end else begin
                state_d = S_LRD;
              end
            end
            default: ;
          endcase
        end
      end

      S_ARD: begin
        if (idx_q >= cnt_q) state_d = S_GROW;
        else state_d = S_ACHK;
      end

      S_ACHK: begin
        if (e_free && e_size == req_q) begin
          mem_we = 1'b1;
          mem_wd = {1'b0, e_size, e_off};
          fin_a  = 1'b1;
          ad_a   = e_off + h;
        end else if (e_free && fit_ge) begin
          if (cnt_q == CntMax) begin
            fin_a = 1'b1;
            st_a  = ffha_pkg::ST_TBL_FULL;
          end else begin
            cur_d = rd_q;
            jdx_d = cnt_q;
            if ({1'b0, cnt_q} > idx_p1) state_d = S_ASHR;
            else state_d = S_SPL1;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_ARD;
        end
      end

      // shift entries up by one to open the slot after the split block
      S_ASHR: begin
        mem_ra  = IW'(jdx_q - CW'(1));
        state_d = S_ASHW;
      end

      S_ASHW: begin
        mem_we = 1'b1;
        mem_wa = jdx_q[IW-1:0];
        mem_wd = rd_q;
        jdx_d  = jdx_q - CW'(1);
        if ({1'b0, jdx_q} - (CW+1)'(1) > idx_p1) state_d = S_ASHR;
        else state_d = S_SPL1;
      end

      S_SPL1: begin
        mem_we  = 1'b1;
        mem_wa  = IW'(idx_p1);
        mem_wd  = {1'b1, c_size - req_q - h, c_off + h + req_q};
        state_d = S_SPL2;
      end

      S_SPL2: begin
        mem_we = 1'b1;
        mem_wd = {1'b0, req_q, c_off};
        cnt_d  = cnt_q + CW'(1);
        fin_a  = 1'b1;
        ad_a   = c_off + h;
      end

      S_GROW: begin
        fin_a = 1'b1;
        if (grow_end > (AW+2)'(lim_a)) begin
          st_a = ffha_pkg::ST_EXHAUSTED;
        end else if (cnt_q == CntMax) begin
          st_a = ffha_pkg::ST_TBL_FULL;
        end else begin
          mem_we = 1'b1;
          mem_wa = cnt_q[IW-1:0];
          mem_wd = {1'b0, req_q, top_q};
          cnt_d  = cnt_q + CW'(1);
          top_d  = grow_end[AW-1:0];
          ad_a   = top_q + h;
        end
      end

      S_LRD: begin
        if (idx_q >= cnt_q) begin
          stat_d  = ffha_pkg::ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          state_d = S_LCHK;
        end
      end

      S_LCHK: begin
        if (!e_free && (e_off + h) == baddr_q) begin
          cur_d = rd_q;
          if (func_q == ffha_pkg::FUNC_REALLOC && req_q != '0 && !frph_q) begin
            oldsz_d = e_size;
            idx_d   = '0;
            state_d = S_ARD;
          end else begin
            state_d = S_FPRD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_LRD;
        end
      end

      S_FPRD: begin
        mem_ra = IW'(idx_q - CW'(1));
        if (idx_q == '0) begin
          phit_d  = 1'b0;
          acc_d   = c_size;
          base_d  = c_off;
          state_d = S_FNRD;
        end else begin
          state_d = S_FPCK;
        end
      end

      S_FPCK: begin
        if (e_free) begin
          phit_d = 1'b1;
          acc_d  = e_size + h + c_size;
          base_d = e_off;
        end else begin
          phit_d = 1'b0;
          acc_d  = c_size;
          base_d = c_off;
        end
        state_d = S_FNRD;
      end

      S_FNRD: begin
        mem_ra = IW'(idx_p1);
        if (idx_p1 < {1'b0, cnt_q}) begin
          state_d = S_FNCK;
        end else begin
          nhit_d  = 1'b0;
          state_d = S_FWR;
        end
      end

      S_FNCK: begin
        nhit_d = e_free;
        if (e_free) acc_d = acc_q + h + e_size;
        state_d = S_FWR;
      end

      S_FWR: begin
        mem_we = 1'b1;
        mem_wa = phit_q ? IW'(idx_q - CW'(1)) : idx_q[IW-1:0];
        mem_wd = {1'b1, acc_q, base_q};
        jdx_d  = phit_q ? idx_q : CW'(idx_p1);
        if (shamt == 2'd0) fin_f = 1'b1;
        else state_d = S_RRD;
      end

      // close the gap left by merged entries
      S_RRD: begin
        mem_ra = IW'(jdx_sh);
        if (jdx_sh >= {1'b0, cnt_q}) begin
          cnt_d = cnt_q - CW'(shamt);
          fin_f = 1'b1;
        end else begin
          state_d = S_RWR;
        end
      end

      S_RWR: begin
        mem_we  = 1'b1;
        mem_wa  = jdx_q[IW-1:0];
        mem_wd  = rd_q;
        jdx_d   = jdx_q + CW'(1);
        state_d = S_RRD;
      end

      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    if (fin_a) begin
      if (st_a == ffha_pkg::ST_OK && func_q == ffha_pkg::FUNC_REALLOC && baddr_q != '0) begin
        frph_d  = 1'b1;
        addr_d  = ad_a;
        copy_d  = (oldsz_q < req_q) ? oldsz_q : req_q;
        idx_d   = '0;
        state_d = S_LRD;
      end else begin
        stat_d  = st_a;
        addr_d  = (st_a == ffha_pkg::ST_OK) ? ad_a : '0;
        state_d = S_DONE;
      end
    end
    if (fin_f) begin
      stat_d  = (func_q == ffha_pkg::FUNC_REALLOC && req_q == '0) ?
                ffha_pkg::ST_ZERO_SIZE : ffha_pkg::ST_OK;
      state_d = S_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_q[mem_wa] <= mem_wd;
    rd_q <= tbl_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hdr_q   <= ffha_pkg::HdrReset;
      lim_q   <= ffha_pkg::LimitReset;
      cnt_q   <= '0;
      top_q   <= '0;
      frph_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      frph_q  <= frph_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ffha_pkg::REG_HEADER) hdr_q <= cfg_data_i[ffha_pkg::HdrW-1:0];
        else lim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    req_q   <= req_d;
    baddr_q <= baddr_d;
    idx_q   <= idx_d;
    jdx_q   <= jdx_d;
    cur_q   <= cur_d;
    acc_q   <= acc_d;
    base_q  <= base_d;
    oldsz_q <= oldsz_d;
    phit_q  <= phit_d;
    nhit_q  <= nhit_d;
    addr_q  <= addr_d;
    copy_q  <= copy_d;
    stat_q  <= stat_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign data_addr_o = addr_q;
  assign status_o    = stat_q;
  assign copy_len_o  = copy_q;

endmodule

>>> rtl/ffha_chk.sv
// ----------------------------------------------------------------------------
// ffha_chk
// Port-level checks of the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_chk #(
  parameter int unsigned AW = 20
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [AW-1:0] data_addr_o,
  input logic [2:0]    status_o,
  input logic [AW-1:0] copy_len_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_addr_o)
      && $stable(status_o) && $stable(copy_len_o))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready for a request while a result is pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("took a second request without working the first");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ffha_pkg::ST_OK |-> data_addr_o == '0 && copy_len_o == '0)
    else $error("failed request reports an address or copy length");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ffha_pkg::ST_UNKNOWN)
    else $error("status code out of range");

endmodule

bind first_fit_heap_allocator ffha_chk #(.AW(ADDR_BITS)) u_ffha_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_addr_o (data_addr_o),
  .status_o    (status_o),
  .copy_len_o  (copy_len_o)
);
